@@ rtl/prd_pkg.sv @@
package prd_pkg;

  localparam int ELEMENTS    = 8;
  localparam int FIELD_COUNT = 8;
  localparam int ELEM_W      = 4;
  localparam int N_ACT       = (ELEMENTS > FIELD_COUNT) ? FIELD_COUNT : ELEMENTS;

  function automatic int fact(input int k);
    int r;
    r = 1;
    for (int i = 2; i <= k; i++) begin
      r = r * i;
    end
    return r;
  endfunction

  localparam int MAP_DEPTH   = fact(N_ACT);
  localparam int RANK_W      = 16;
  localparam int CNT_W       = 16;
  localparam int DIG_W       = $clog2(N_ACT);
  localparam int ROW_BITS    = 8;
  localparam int SEL_W       = $clog2(ROW_BITS);
  localparam int MAP_ROWS    = (MAP_DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W       = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [FIELD_COUNT-1:0] elem_vec_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              bad;
  } prd_item_t;

  typedef struct packed {
    logic      vld;
    prd_item_t item;
  } prd_req_t;

endpackage

@@ rtl/permutation_rank_dedup.sv @@
// Ranks each request as a permutation of 1..8 (Lehmer code, 0..40319), checks
// and sets its bit in a 40320-entry visited bitmap, and reports the rank, a
// seen-before flag, an invalid flag (values not distinct in 1..8; rank 0, bitmap
// untouched) and the running count of distinct permutations. After reset the
// bitmap is swept clear, 8 bits a cycle, over all 5040 rows; requests are taken
// into the front meanwhile but no result leaves until the sweep ends. The
// back end takes a new request only once it has finished the last: it reads
// the bitmap row as it pops a request, then writes the row back for a new
// permutation and registers the result. A request passes the ranking registers,
// the 2-entry queue, the row read and the result register; the queue between
// ranking and bitmap lets each side stall on its own.
module permutation_rank_dedup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_0,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_1,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_2,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_3,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_4,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_5,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_6,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_7,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prd_pkg::RANK_W-1:0]  perm_rank,
  output logic                        seen_before,
  output logic                        not_permutation,
  output logic [prd_pkg::CNT_W-1:0]   distinct_count
);

  prd_pkg::elem_vec_t elems;
  prd_pkg::prd_req_t  push;
  prd_pkg::prd_req_t  head;
  logic               push_ready;
  logic               pop;

  assign elems = {elem_7, elem_6, elem_5, elem_4, elem_3, elem_2, elem_1, elem_0};

  prd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .elems      (elems),
    .push       (push),
    .push_ready (push_ready)
  );

  prd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  prd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .perm_rank       (perm_rank),
    .seen_before     (seen_before),
    .not_permutation (not_permutation),
    .distinct_count  (distinct_count)
  );

endmodule

@@ rtl/prd_front.sv @@
module prd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  prd_pkg::elem_vec_t elems,
  output prd_pkg::prd_req_t push,
  input  logic              push_ready
);

  logic                  a_vld;
  prd_pkg::elem_vec_t    a_elem;
  logic                  b_vld;
  logic                  b_bad;
  logic [prd_pkg::N_ACT-1:0][prd_pkg::DIG_W-1:0] b_dig;

  logic                  bad_next;
  logic [prd_pkg::N_ACT-1:0][prd_pkg::DIG_W-1:0] dig_next;
  logic [prd_pkg::RANK_W-1:0] rank;
  logic                  b_free;

  assign b_free   = !b_vld || push_ready;
  assign in_ready = !a_vld || b_free;

  // validity and lehmer digits (later smaller values)
  always_comb begin
    bad_next = 1'b0;
    for (int i = 0; i < prd_pkg::N_ACT; i++) begin
      dig_next[i] = '0;
      if (a_elem[i] == '0 || a_elem[i] > prd_pkg::ELEM_W'(prd_pkg::N_ACT)) begin
        bad_next = 1'b1;
      end
      for (int j = i + 1; j < prd_pkg::N_ACT; j++) begin
        if (a_elem[i] == a_elem[j]) begin
          bad_next = 1'b1;
        end
        if (a_elem[j] < a_elem[i]) begin
          dig_next[i] = dig_next[i] + prd_pkg::DIG_W'(1);
        end
      end
    end
  end

  // weighted sum by factorials
  always_comb begin
    rank = '0;
    for (int i = 0; i < prd_pkg::N_ACT; i++) begin
      rank = rank + prd_pkg::RANK_W'(b_dig[i]) *
             prd_pkg::RANK_W'(prd_pkg::fact(prd_pkg::N_ACT - 1 - i));
    end
    if (b_bad) begin
      rank = '0;
    end
  end

  assign push.vld       = b_vld;
  assign push.item.rank = rank;
  assign push.item.bad  = b_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      if (in_ready) begin
        a_vld <= in_valid;
      end
      if (b_free) begin
        b_vld <= a_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      a_elem <= elems;
    end
    if (b_free) begin
      b_dig <= dig_next;
      b_bad <= bad_next;
    end
  end

endmodule

@@ rtl/prd_queue.sv @@
module prd_queue (
  input  logic              clk,
  input  logic              rst,
  input  prd_pkg::prd_req_t push,
  output logic              push_ready,
  output prd_pkg::prd_req_t head,
  input  logic              pop
);

  prd_pkg::prd_item_t           entries [prd_pkg::QUEUE_DEPTH];
  logic [prd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [prd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [prd_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = count != prd_pkg::QCNT_W'(prd_pkg::QUEUE_DEPTH);
  assign head.vld   = count != '0;
  assign head.item  = entries[rd_ptr];
  assign do_push    = push.vld && push_ready;
  assign do_pop     = pop && head.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + prd_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + prd_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + prd_pkg::QCNT_W'(1);
        2'b01:   count <= count - prd_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

endmodule

@@ rtl/prd_back.sv @@
module prd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  prd_pkg::prd_req_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [prd_pkg::RANK_W-1:0]  perm_rank,
  output logic                        seen_before,
  output logic                        not_permutation,
  output logic [prd_pkg::CNT_W-1:0]   distinct_count
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]                      state;
  logic [1:0]                      state_next;
  logic [prd_pkg::ROW_W-1:0]       clr_row;
  prd_pkg::prd_item_t              cur;
  logic [prd_pkg::CNT_W-1:0]       total;

  logic [prd_pkg::ROW_BITS-1:0]    mem [prd_pkg::MAP_ROWS];
  logic [prd_pkg::ROW_BITS-1:0]    rdata;
  logic                            mem_we;
  logic [prd_pkg::ROW_W-1:0]       mem_waddr;
  logic [prd_pkg::ROW_BITS-1:0]    mem_wdata;
  logic [prd_pkg::ROW_W-1:0]       mem_raddr;

  logic                            fire;
  logic                            seen;
  logic                            mark;
  logic [prd_pkg::SEL_W-1:0]       sel;

  assign sel       = cur.rank[prd_pkg::SEL_W-1:0];
  assign pop       = (state == ST_IDLE) && head.vld;
  assign mem_raddr = head.item.rank[prd_pkg::SEL_W +: prd_pkg::ROW_W];
  assign fire      = (state == ST_READ) && (!out_valid || out_ready);
  assign seen      = rdata[sel] && !cur.bad;
  assign mark      = fire && !cur.bad && !seen;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur.rank[prd_pkg::SEL_W +: prd_pkg::ROW_W];
    mem_wdata = rdata | (prd_pkg::ROW_BITS'(1) << sel);
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_row;
      mem_wdata = '0;
    end else if (mark) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_row == prd_pkg::ROW_W'(prd_pkg::MAP_ROWS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_row   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + prd_pkg::ROW_W'(1);
      end
      if (mark) begin
        total <= total + prd_pkg::CNT_W'(1);
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head.item;
      rdata <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (fire) begin
      perm_rank       <= cur.rank;
      seen_before     <= seen;
      not_permutation <= cur.bad;
      distinct_count  <= mark ? total + prd_pkg::CNT_W'(1) : total;
    end
  end

endmodule

@@ rtl/prd_checker.sv @@
module prd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prd_pkg::RANK_W-1:0]  perm_rank,
  input logic                        seen_before,
  input logic                        not_permutation,
  input logic [prd_pkg::CNT_W-1:0]   distinct_count
);

  logic [prd_pkg::CNT_W-1:0] last_count;

  // count reported by the last delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
    end else if (out_valid && out_ready) begin
      last_count <= distinct_count;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(perm_rank) && $stable(distinct_count))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_permutation |-> perm_rank == '0 && !seen_before)
    else $error("invalid request with nonzero rank or seen flag");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> perm_rank < prd_pkg::RANK_W'(prd_pkg::MAP_DEPTH))
    else $error("rank out of range");

  a_new_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && !not_permutation && !seen_before |->
      distinct_count == last_count + prd_pkg::CNT_W'(1))
    else $error("new permutation did not bump count");

  a_no_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && (not_permutation || seen_before) |-> distinct_count == last_count)
    else $error("count moved without a new permutation");

endmodule

bind permutation_rank_dedup prd_checker u_chk (.*);

@@ tb/permutation_rank_dedup_checker.sv @@
`timescale 1ns / 1ps

module permutation_rank_dedup_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_0,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_1,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_2,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_3,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_4,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_5,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_6,
  input  logic [prd_pkg::ELEM_W-1:0]  elem_7,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [prd_pkg::RANK_W-1:0]  perm_rank,
  input  logic                        seen_before,
  input  logic                        not_permutation,
  input  logic [prd_pkg::CNT_W-1:0]   distinct_count,
  output int                          failures,
  output int                          outstanding
);

  typedef struct packed {
    logic [prd_pkg::RANK_W-1:0] rank;
    logic                       seen;
    logic                       bad;
    logic [prd_pkg::CNT_W-1:0]  count;
  } rank_result_t;

  bit                         seen_map [prd_pkg::MAP_DEPTH];
  logic [prd_pkg::CNT_W-1:0]  marked_total;
  rank_result_t               rank_results_due [$];
  rank_result_t               due;
  int                         errors = 0;

  function automatic rank_result_t rank_and_mark(input prd_pkg::elem_vec_t v);
    rank_result_t r;
    bit           taken [16];
    int unsigned  below [prd_pkg::FIELD_COUNT];
    int unsigned  rank_acc;
    int unsigned  weight;
    bit           ok;
    ok = 1'b1;
    foreach (taken[k]) taken[k] = 1'b0;
    for (int i = 0; i < prd_pkg::N_ACT; i++) begin
      if (v[i] == 0 || v[i] > prd_pkg::N_ACT || taken[v[i]]) begin
        ok = 1'b0;
      end else begin
        taken[v[i]] = 1'b1;
      end
    end
    r = '0;
    r.count = marked_total;
    if (!ok) begin
      r.bad = 1'b1;
      return r;
    end
    // lehmer digits: smaller values not yet used at each position
    foreach (taken[k]) taken[k] = 1'b0;
    for (int i = 0; i < prd_pkg::N_ACT; i++) begin
      below[i] = 0;
      for (int u = 1; u < v[i]; u++) begin
        if (!taken[u]) below[i]++;
      end
      taken[v[i]] = 1'b1;
    end
    rank_acc = 0;
    weight = 1;
    for (int i = prd_pkg::N_ACT - 1; i >= 0; i--) begin
      rank_acc += below[i] * weight;
      weight *= prd_pkg::N_ACT - i;
    end
    r.rank = rank_acc[prd_pkg::RANK_W-1:0];
    r.seen = seen_map[rank_acc];
    if (!r.seen) begin
      seen_map[rank_acc] = 1'b1;
      if (marked_total != '1) marked_total++;
    end
    r.count = marked_total;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (seen_map[k]) seen_map[k] = 1'b0;
      marked_total = '0;
      rank_results_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        rank_results_due.push_back(rank_and_mark({elem_7, elem_6, elem_5, elem_4,
                                                  elem_3, elem_2, elem_1, elem_0}));
      end
      if (out_valid && out_ready) begin
        if (rank_results_due.size() == 0) begin
          $display("%0t unexpected result: rank %0d seen %0d invalid %0d count %0d",
                   $time, perm_rank, seen_before, not_permutation, distinct_count);
          errors++;
        end else begin
          due = rank_results_due.pop_front();
          check_field("perm_rank", 32'(due.rank), 32'(perm_rank));
          check_field("seen_before", 32'(due.seen), 32'(seen_before));
          check_field("not_permutation", 32'(due.bad), 32'(not_permutation));
          check_field("distinct_count", 32'(due.count), 32'(distinct_count));
        end
      end
    end
    outstanding <= rank_results_due.size();
    failures <= errors;
  end

endmodule

@@ tb/permutation_rank_dedup_test.sv @@
`timescale 1ns / 1ps

module permutation_rank_dedup_test;

  localparam int REQUESTS = 1450;
  localparam int HISTORY_MAX = 64;

  // packed element lists, elem_0 in the low nibble
  localparam logic [31:0] DIRECTED [15] = '{
    32'h8765_4321,  // identity
    32'h8765_4321,  // identity again
    32'h1234_5678,  // reverse
    32'h7865_4321,  // last two swapped
    32'h0000_0000,
    32'hFFFF_FFFF,
    32'h8765_4320,  // zero in front
    32'h9765_4321,  // value above range
    32'h8765_4311,  // repeated value
    32'hF765_4321,
    32'h7654_3218,  // largest leading value
    32'h1234_5678,  // reverse again
    32'h7765_4321,
    32'h8FED_CBA9,
    32'h2143_6587
  };

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [prd_pkg::ELEM_W-1:0]   elem_0 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_1 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_2 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_3 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_4 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_5 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_6 = '0;
  logic [prd_pkg::ELEM_W-1:0]   elem_7 = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [prd_pkg::RANK_W-1:0]   perm_rank;
  logic                         seen_before;
  logic                         not_permutation;
  logic [prd_pkg::CNT_W-1:0]    distinct_count;
  int                           failures;
  int                           outstanding;
  int                           send_gap_pct = 20;
  int                           take_gap_pct = 20;
  prd_pkg::elem_vec_t           history [$];

  permutation_rank_dedup dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
    .elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6), .elem_7(elem_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .perm_rank(perm_rank), .seen_before(seen_before),
    .not_permutation(not_permutation), .distinct_count(distinct_count)
  );

  permutation_rank_dedup_checker rank_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .elem_0(elem_0), .elem_1(elem_1), .elem_2(elem_2), .elem_3(elem_3),
    .elem_4(elem_4), .elem_5(elem_5), .elem_6(elem_6), .elem_7(elem_7),
    .out_valid(out_valid), .out_ready(out_ready),
    .perm_rank(perm_rank), .seen_before(seen_before),
    .not_permutation(not_permutation), .distinct_count(distinct_count),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= take_gap_pct);
  end

  function automatic prd_pkg::elem_vec_t shuffled_perm();
    prd_pkg::elem_vec_t v;
    prd_pkg::elem_t     t;
    int                 j;
    v = $urandom();
    for (int i = 0; i < prd_pkg::N_ACT; i++) v[i] = prd_pkg::elem_t'(i + 1);
    for (int i = prd_pkg::N_ACT - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = v[i];
      v[i] = v[j];
      v[j] = t;
    end
    return v;
  endfunction

  function automatic prd_pkg::elem_vec_t next_candidate();
    prd_pkg::elem_vec_t v;
    prd_pkg::elem_t     t;
    int                 kind;
    int                 a;
    int                 b;
    kind = $urandom_range(99);
    if (kind < 55 || history.size() == 0) begin
      v = shuffled_perm();
    end else if (kind < 75) begin
      v = history[$urandom_range(history.size() - 1)];
    end else if (kind < 85) begin
      // near neighbor of an earlier permutation
      v = history[$urandom_range(history.size() - 1)];
      a = $urandom_range(prd_pkg::N_ACT - 1);
      b = $urandom_range(prd_pkg::N_ACT - 1);
      t = v[a];
      v[a] = v[b];
      v[b] = t;
    end else if (kind < 93) begin
      v = shuffled_perm();
      v[$urandom_range(prd_pkg::N_ACT - 1)] = prd_pkg::elem_t'($urandom_range(15));
      return v;
    end else begin
      return prd_pkg::elem_vec_t'($urandom());
    end
    history.push_back(v);
    if (history.size() > HISTORY_MAX) void'(history.pop_front());
    return v;
  endfunction

  task automatic send_request(input prd_pkg::elem_vec_t v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    elem_0 <= v[0];
    elem_1 <= v[1];
    elem_2 <= v[2];
    elem_3 <= v[3];
    elem_4 <= v[4];
    elem_5 <= v[5];
    elem_6 <= v[6];
    elem_7 <= v[7];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[k]) send_request(DIRECTED[k]);
    wait_for_drain();
    for (int k = 0; k < REQUESTS - $size(DIRECTED); k++) begin
      if (k == 500) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end
      if (k == 800) begin
        send_gap_pct = 20;
        take_gap_pct = 20;
      end
      if (k == 1000) wait_for_drain();
      send_request(next_candidate());
    end
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
